// File: rtl/cslr_pkg.sv
`timescale 1ns / 1ps

package cslr_pkg;

   // Geometry of the set
   localparam int WAYS      = 8;
   localparam int ADDR_BITS = 40;
   localparam int WAY_W     = $clog2(WAYS);
   localparam int CNT_W     = $clog2(WAYS + 1);
   localparam int RANK_W    = WAY_W;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int WIU_W     = 4;
   localparam int SEED_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOCATE_ON_READ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED      = 2'd3;

   // Register encodings and reset values
   localparam logic             MODE_LRU      = 1'b0;
   localparam logic             MODE_RANDOM   = 1'b1;
   localparam logic             FUNC_STORE    = 1'b1;
   localparam logic [WIU_W-1:0] WIU_RESET     = 4'd8;
   localparam logic [SEED_W-1:0] SEED_RESET   = 32'd1;

   // Galois LFSR, shifting right
   localparam logic [SEED_W-1:0] LFSR_MASK    = 32'h8020_0003;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request transfer
      logic lookup;    // compare tags, pick candidate victims
      logic resolve;   // update the set and load the result register
   } cslr_cmd_type;

endpackage

// File: rtl/cslr_ctrl.sv
`timescale 1ns / 1ps

module cslr_ctrl
   import cslr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output cslr_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_RESOLVE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      resolve_go;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // resolve only once the result register is free or being emptied
   assign resolve_go = (state_ff == S_RESOLVE) && (!rsp_valid_ff || rsp_tready);

   assign cmd.capture = req_tvalid && (state_ff == S_IDLE);
   assign cmd.lookup  = (state_ff == S_LOOKUP);
   assign cmd.resolve = resolve_go;

   // next state and result valid flag
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (resolve_go) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resolve_go)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/cslr_datapath.sv
`timescale 1ns / 1ps

module cslr_datapath
   import cslr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cslr_cmd_type         cmd,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 func,
   input  logic [ADDR_BITS-1:0] line_address,
   output logic                 hit,
   output logic                 evicted,
   output logic [ADDR_BITS-1:0] victim_address
);

   localparam int PROD_W = SEED_W + CNT_W;

   // configuration
   logic              replace_mode_ff, replace_mode_in;
   logic              alloc_read_ff, alloc_read_in;
   logic [WIU_W-1:0]  ways_in_use_ff, ways_in_use_in;
   logic [SEED_W-1:0] random_state_ff, random_state_in;

   // set contents
   logic [ADDR_BITS-1:0] tags_ff [WAYS];
   logic [ADDR_BITS-1:0] tags_in [WAYS];
   logic [RANK_W-1:0]    rank_ff [WAYS];
   logic [RANK_W-1:0]    rank_in [WAYS];
   logic [CNT_W-1:0]     fill_ff, fill_in;

   // captured request
   logic                 func_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // lookup results
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]  lru_way_ff, lru_way_in;
   logic [WAY_W-1:0]  rand_way_ff, rand_way_in;
   logic [SEED_W-1:0] lfsr_next_ff, lfsr_next_in;

   // result register
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_evicted_ff, rsp_evicted_in;
   logic [ADDR_BITS-1:0] rsp_victim_ff, rsp_victim_in;

   logic [CNT_W-1:0]     way_limit;
   logic [PROD_W-1:0]    rand_prod;
   logic                 do_alloc;
   logic                 do_fill;
   logic                 do_evict;
   logic                 do_promote;
   logic [WAY_W-1:0]     evict_way;
   logic [WAY_W-1:0]     promote_way;
   logic [RANK_W-1:0]    promote_rank;
   logic [WAY_W-1:0]     fill_way;

   assign hit            = rsp_hit_ff;
   assign evicted        = rsp_evicted_ff;
   assign victim_address = rsp_victim_ff;

   // way limit: zero acts as one, anything above the way count saturates
   always_comb begin
      if (ways_in_use_ff == '0)                   way_limit = CNT_W'(1);
      else if (32'(ways_in_use_ff) > 32'(WAYS))   way_limit = CNT_W'(WAYS);
      else                                        way_limit = CNT_W'(ways_in_use_ff);
   end

   // lookup: parallel tag compare, LRU candidate, random candidate
   always_comb begin
      hit_in     = 1'b0;
      hit_way_in = '0;
      lru_way_in = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (fill_ff > CNT_W'(i)) begin
            if (!hit_in && tags_ff[i] == addr_ff) begin
               hit_in     = 1'b1;
               hit_way_in = WAY_W'(i);
            end
            if (rank_ff[i] == '0) lru_way_in = WAY_W'(i);
         end
      end
      lfsr_next_in = (random_state_ff >> 1) ^ (random_state_ff[0] ? LFSR_MASK : '0);
      rand_prod    = PROD_W'(lfsr_next_in) * PROD_W'(way_limit);
      rand_way_in  = rand_prod[SEED_W +: WAY_W];
   end

   // resolve decisions
   always_comb begin
      do_alloc     = (func_ff == FUNC_STORE) || alloc_read_ff;
      do_fill      = !hit_ff && do_alloc && (fill_ff < way_limit);
      do_evict     = !hit_ff && do_alloc && !(fill_ff < way_limit);
      evict_way    = (replace_mode_ff == MODE_RANDOM) ? rand_way_ff : lru_way_ff;
      do_promote   = (hit_ff && replace_mode_ff == MODE_LRU) || do_evict;
      promote_way  = hit_ff ? hit_way_ff : evict_way;
      promote_rank = rank_ff[promote_way];
      fill_way     = fill_ff[WAY_W-1:0];
   end

   // state and result update
   always_comb begin
      replace_mode_in = replace_mode_ff;
      alloc_read_in   = alloc_read_ff;
      ways_in_use_in  = ways_in_use_ff;
      random_state_in = random_state_ff;
      tags_in         = tags_ff;
      rank_in         = rank_ff;
      fill_in         = fill_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_victim_in   = rsp_victim_ff;

      // register writes; the user must write only while idle, the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_REPLACE_MODE:     replace_mode_in = csr_wdata[0];
            CSR_ALLOCATE_ON_READ: alloc_read_in   = csr_wdata[0];
            CSR_WAYS_IN_USE:      ways_in_use_in  = csr_wdata[WIU_W-1:0];
            CSR_RANDOM_SEED: begin
               random_state_in = (csr_wdata[SEED_W-1:0] == '0) ? SEED_RESET
                                                               : csr_wdata[SEED_W-1:0];
            end
            default: ;
         endcase
      end

      if (cmd.resolve) begin
         rsp_hit_in     = hit_ff;
         rsp_evicted_in = do_evict;
         rsp_victim_in  = do_evict ? tags_ff[evict_way] : '0;

         // move every younger valid way down one rank, target to the top
         if (do_promote) begin
            for (int i = 0; i < WAYS; i++) begin
               if (fill_ff > CNT_W'(i) && rank_ff[i] > promote_rank)
                  rank_in[i] = rank_ff[i] - RANK_W'(1);
            end
            rank_in[promote_way] = RANK_W'(fill_ff - CNT_W'(1));
         end

         if (do_fill) begin
            tags_in[fill_way] = addr_ff;
            rank_in[fill_way] = RANK_W'(fill_ff);
            fill_in           = fill_ff + CNT_W'(1);
         end

         if (do_evict) begin
            tags_in[evict_way] = addr_ff;
            if (replace_mode_ff == MODE_RANDOM) random_state_in = lfsr_next_ff;
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         replace_mode_ff <= MODE_LRU;
         alloc_read_ff   <= 1'b1;
         ways_in_use_ff  <= WIU_RESET;
         random_state_ff <= SEED_RESET;
         fill_ff         <= '0;
      end else begin
         replace_mode_ff <= replace_mode_in;
         alloc_read_ff   <= alloc_read_in;
         ways_in_use_ff  <= ways_in_use_in;
         random_state_ff <= random_state_in;
         fill_ff         <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tags_ff        <= tags_in;
      rank_ff        <= rank_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_victim_ff  <= rsp_victim_in;
      if (cmd.capture) begin
         func_ff <= func;
         addr_ff <= line_address;
      end
      if (cmd.lookup) begin
         hit_ff       <= hit_in;
         hit_way_ff   <= hit_way_in;
         lru_way_ff   <= lru_way_in;
         rand_way_ff  <= rand_way_in;
         lfsr_next_ff <= lfsr_next_in;
      end
   end

endmodule

// File: rtl/cache_set_lru_random_replace_unit.sv
`timescale 1ns / 1ps

// One set of an eight-way cache with LRU or random replacement. Each request
// transfer is a load or store of a line address, and each one yields exactly
// one response transfer. That response carries hit, evicted and the evicted
// line address, which is zero when nothing is evicted. An access is captured
// on its transfer; then the parallel tag compare and the victim selection are
// registered; then tags, ranks and the random generator are updated and the
// response register is loaded. A new request is taken only after the previous
// access has passed the update step; the request side opens again while a
// response still waits. Only the update step stalls, and only while the
// response register is full and not being emptied. The random victim comes
// from a 32-bit Galois LFSR scaled by the ways in use. A write of the seed
// reloads it at once, and a zero seed loads one. Write registers only while
// the set is idle.

module cache_set_lru_random_replace_unit
   import cslr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,   // [39:0] line_address
   input  logic [0:0]           req_tuser,   // [0] func (0 load, 1 store)
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [39:0] victim_address
   output logic [1:0]           rsp_tuser,   // [0] hit, [1] evicted
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cslr_cmd_type cmd;

   cslr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cslr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .func           (req_tuser[0]),
      .line_address   (req_tdata[ADDR_BITS-1:0]),
      .hit            (rsp_tuser[0]),
      .evicted        (rsp_tuser[1]),
      .victim_address (rsp_tdata[ADDR_BITS-1:0])
   );

endmodule

// File: test/cache_set_lru_random_replace_unit_tb.sv
`timescale 1ns / 1ps

module cache_set_lru_random_replace_unit_tb;
   import cslr_pkg::*;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam int   DRAIN_CYCLES = 8;
   localparam int   LONG_HOLD    = 300;
   localparam int   MAX_REPORTS  = 40;
   localparam int   PHASES       = 16;
   localparam int   PHASE_ITEMS  = 105;

   typedef struct packed {
      logic                 func;
      logic [ADDR_BITS-1:0] line_address;
   } access_type;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [ADDR_BITS-1:0] victim_address;
   } outcome_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata  = '0;   // [39:0] line_address
   logic [0:0]           req_tuser  = '0;   // [0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;         // [39:0] victim_address
   logic [1:0]           rsp_tuser;         // [0] hit, [1] evicted
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_wdata  = '0;

   cache_set_lru_random_replace_unit dut (.*);

   always #2 clock = ~clock;

   // Shadow copy of the set and its registers
   logic [ADDR_BITS-1:0] tag_of [WAYS];
   logic [RANK_W-1:0]    rank_of [WAYS];
   int unsigned          valid_ways;
   logic [SEED_W-1:0]    victim_lfsr;
   logic                 cfg_mode;
   logic                 cfg_alloc;
   logic [WIU_W-1:0]     cfg_ways;

   access_type  pending_accesses [$];
   outcome_type predicted_outcomes [$];

   // Traffic shaping
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned req_gap      = 0;
   int unsigned rsp_gap      = 0;
   int unsigned rsp_hold     = 0;
   int unsigned hold_asks    = 0;
   int unsigned hold_grants  = 0;
   bit          offer_live   = 1'b0;

   // Tallies
   int unsigned error_count   = 0;
   int unsigned hit_count     = 0;
   int unsigned fill_count    = 0;
   int unsigned evict_count   = 0;
   int unsigned bypass_count  = 0;
   int unsigned setting_count = 0;

   function automatic int unsigned pick_gap(int unsigned pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [ADDR_BITS-1:0] random_address();
      return ADDR_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic void queue_access(logic func, logic [ADDR_BITS-1:0] addr);
      pending_accesses.push_back('{func: func, line_address: addr});
   endfunction

   function automatic void flag_error(string what, logic [ADDR_BITS-1:0] want,
                                      logic [ADDR_BITS-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("t=%0t %s differs: expected %h, actual %h", $time, what, want, got);
   endfunction

   // Move way w to the top of the recency order
   function automatic void make_newest(int unsigned w);
      logic [RANK_W-1:0] r;
      r = rank_of[w];
      for (int i = 0; i < valid_ways; i++)
         if (rank_of[i] > r) rank_of[i]--;
      rank_of[w] = RANK_W'(valid_ways - 1);
   endfunction

   // Work out the outcome of one access and update the shadow set
   function automatic void predict_lookup(logic func, logic [ADDR_BITS-1:0] addr);
      outcome_type o;
      int unsigned limit;
      int unsigned w;
      logic        lsb;
      o = '0;
      limit = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS) ? WAYS : cfg_ways;
      w = WAYS;
      for (int i = 0; i < valid_ways; i++)
         if (w == WAYS && tag_of[i] == addr) w = i;
      if (w != WAYS) begin
         o.hit = 1'b1;
         if (cfg_mode == MODE_LRU) make_newest(w);
         hit_count++;
      end else if (func != FUNC_STORE && !cfg_alloc) begin
         bypass_count++;
      end else if (valid_ways < limit) begin
         tag_of[valid_ways]  = addr;
         rank_of[valid_ways] = RANK_W'(valid_ways);
         valid_ways++;
         fill_count++;
      end else begin
         if (cfg_mode == MODE_LRU) begin
            w = 0;
            for (int i = 0; i < valid_ways; i++)
               if (rank_of[i] == 0) w = i;
         end else begin
            lsb = victim_lfsr[0];
            victim_lfsr = victim_lfsr >> 1;
            if (lsb) victim_lfsr ^= LFSR_MASK;
            w = int'((64'(victim_lfsr) * 64'(limit)) >> 32);
         end
         o.evicted        = 1'b1;
         o.victim_address = tag_of[w];
         tag_of[w]        = addr;
         make_newest(w);
         evict_count++;
      end
      predicted_outcomes.push_back(o);
   endfunction

   // Request driver: one access offered at a time, held until its transfer
   always @(posedge clock) begin
      access_type next_access;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_lookup(req_tuser[0], req_tdata);
            offer_live = 1'b0;
         end
         if (!offer_live) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               next_access = pending_accesses.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_access.line_address;
               req_tuser  <= next_access.func;
               offer_live = 1'b1;
               req_gap    = pick_gap(req_idle_pct);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_outcomes.size() == 0) begin
               error_count++;
               $display("t=%0t response: expected none, actual %b/%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_tuser[0] !== want.hit)
                  flag_error("hit", want.hit, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.evicted)
                  flag_error("evicted", want.evicted, rsp_tuser[1]);
               if (rsp_tdata !== want.victim_address)
                  flag_error("victim_address", want.victim_address, rsp_tdata);
            end
         end
         if (hold_grants != hold_asks) begin
            hold_grants++;
            rsp_hold = LONG_HOLD;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_gap = pick_gap(rsp_idle_pct);
            rsp_tready <= (rsp_gap == 0);
         end
      end
   end

   // Wait until every access has been answered, then let the pipe empty
   task automatic settle();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || offer_live || predicted_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_REPLACE_MODE:     cfg_mode  = val[0];
         CSR_ALLOCATE_ON_READ: cfg_alloc = val[0];
         CSR_WAYS_IN_USE:      cfg_ways  = val[WIU_W-1:0];
         CSR_RANDOM_SEED:      victim_lfsr = (val == 0) ? SEED_W'(1) : val;
         default: ;
      endcase
      setting_count++;
   endtask

   // Mostly reuse of a small address pool so hits and evictions are frequent
   task automatic random_phase(int unsigned n_items);
      logic [ADDR_BITS-1:0] pool [$];
      int unsigned          pool_size;
      int unsigned          pick;
      pool_size = $urandom_range(cfg_ways + 6, 2);
      repeat (pool_size) pool.push_back(random_address());
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < 85)
            queue_access(1'($urandom_range(1)), pool[$urandom_range(pool_size - 1)]);
         else if (pick < 97)
            queue_access(1'($urandom_range(1)), random_address());
         else
            queue_access(1'($urandom_range(1)), pick[0] ? '1 : '0);
      end
   endtask

   // Stimulus sequence
   initial begin
      cfg_mode    = MODE_LRU;
      cfg_alloc   = 1'b1;
      cfg_ways    = WIU_RESET;
      victim_lfsr = SEED_RESET;
      valid_ways  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // cold set: fills, hits at both address extremes, then an LRU eviction
      queue_access(FUNC_STORE, '0);
      queue_access(FUNC_LOAD, '1);
      queue_access(FUNC_LOAD, '0);
      queue_access(FUNC_STORE, '1);
      repeat (6) queue_access(1'($urandom_range(1)), random_address());
      queue_access(FUNC_STORE, random_address());
      queue_access(FUNC_LOAD, '1);

      // load miss without allocation, store miss still allocates
      settle();
      write_csr(CSR_ALLOCATE_ON_READ, 0);
      queue_access(FUNC_LOAD, random_address());
      queue_access(FUNC_STORE, random_address());

      // random victims from a zero seed, which must load as one
      settle();
      write_csr(CSR_REPLACE_MODE, CSR_DAT_W'(MODE_RANDOM));
      write_csr(CSR_RANDOM_SEED, 0);
      repeat (3) queue_access(FUNC_STORE, random_address());

      // limit lowered below the fill level, random then LRU
      settle();
      write_csr(CSR_WAYS_IN_USE, 2);
      repeat (2) queue_access(FUNC_STORE, random_address());
      settle();
      write_csr(CSR_REPLACE_MODE, CSR_DAT_W'(MODE_LRU));
      queue_access(FUNC_STORE, random_address());

      // out of range way limits
      settle();
      write_csr(CSR_WAYS_IN_USE, 0);
      queue_access(FUNC_STORE, random_address());
      settle();
      write_csr(CSR_WAYS_IN_USE, 12);
      queue_access(FUNC_STORE, random_address());

      // random phases, each under its own register setting
      for (int k = 0; k < PHASES; k++) begin
         settle();
         write_csr(CSR_REPLACE_MODE, k % 2);
         write_csr(CSR_ALLOCATE_ON_READ, (k / 2) % 2);
         write_csr(CSR_WAYS_IN_USE, (k % 4 == 0) ? 1 : (k % 4 == 1) ? 8 :
                                    $urandom_range(8, 1));
         write_csr(CSR_RANDOM_SEED, (k == 1) ? 32'hFFFF_FFFF : (k == 5) ? 1 : $urandom());
         req_idle_pct = (k % 5 == 0) ? 0 : $urandom_range(40, 5);
         rsp_idle_pct = (k % 4 == 0) ? 0 : $urandom_range(40, 5);
         if (k == 3) begin
            // sink stalls for a long stretch while the source keeps offering
            req_idle_pct = 0;
            hold_asks++;
         end
         random_phase(PHASE_ITEMS);
      end

      settle();
      $display("Checked %0d accesses: %0d hits, %0d fills, %0d evictions, %0d uncached loads",
               hit_count + fill_count + evict_count + bypass_count,
               hit_count, fill_count, evict_count, bypass_count);
      $display("over %0d register writes, LRU and random victims, 1 to 8 ways in use",
               setting_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
